// File: rtl/msp_pkg.sv
// shared types, codes and helpers of the serial port register block
package msp_pkg;

  typedef enum logic [1:0] {
    REQ_READ     = 2'd0,
    REQ_WRITE    = 2'd1,
    REQ_RX_CHECK = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  localparam logic [1:0] WORD_RX_STATUS = 2'd0;
  localparam logic [1:0] WORD_RX_DATA   = 2'd1;
  localparam logic [1:0] WORD_TX_STATUS = 2'd2;
  localparam logic [1:0] WORD_TX_DATA   = 2'd3;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_SWAP   = 1'b0;

  localparam int unsigned IE_BIT   = 1;
  localparam logic        TX_READY = 1'b1;
  localparam logic [1:0]  OFFER_MAX = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  word_index;
    logic [31:0] write_data;
    logic        debug_access;
    logic [1:0]  rx_offered;
    logic [7:0]  rx_first;
    logic [7:0]  rx_second;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic [1:0]  rx_consumed;
    logic        tx_valid;
    logic [7:0]  tx_out;
    logic        rx_irq;
    logic        tx_irq;
    logic        rx_irq_changed;
    logic        tx_irq_changed;
    logic [31:0] bytes_taken;
  } result_t;

  typedef struct packed {
    logic       ready;
    logic [7:0] held;
    logic [1:0] used;
  } rx_work_t;

  function automatic logic [31:0] byte_reverse(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// File: rtl/msp_apb.sv
// configuration register behind the apb-style port
module msp_apb (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic                            swap
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap <= 1'b0;
    end else if (wr && paddr[msp_pkg::CFG_ADDR_W-1] == msp_pkg::REG_SWAP) begin
      swap <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[msp_pkg::CFG_ADDR_W-1] == msp_pkg::REG_SWAP) begin
      prdata = {31'd0, swap};
    end
  end

endmodule

// File: rtl/msp_core.sv
// register state and the single-step access logic
module msp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             swap,
  input  msp_pkg::item_t   item,
  output msp_pkg::result_t result
);

  logic        rx_ready;
  logic        rx_enable;
  logic [7:0]  rx_byte_held;
  logic        tx_enable;
  logic        rx_line;
  logic        tx_line;
  logic [31:0] take_count;

  logic        rx_enable_next;
  logic        tx_enable_next;
  logic        rx_line_next;
  logic        tx_line_next;
  logic [31:0] take_count_next;

  msp_pkg::rx_work_t w;
  logic [1:0]  offer_n;
  logic [31:0] wd;
  logic [31:0] rdata;
  logic        ok;
  logic        txv;
  logic [7:0]  txb;

  function automatic msp_pkg::rx_work_t pull(msp_pkg::rx_work_t s, logic [1:0] n,
                                             logic [7:0] b0, logic [7:0] b1);
    msp_pkg::rx_work_t r;
    r = s;
    if (!s.ready && s.used < n) begin
      r.held  = s.used[0] ? b1 : b0;
      r.used  = s.used + 2'd1;
      r.ready = 1'b1;
    end
    return r;
  endfunction

  assign offer_n = (item.rx_offered > msp_pkg::OFFER_MAX) ? msp_pkg::OFFER_MAX
                                                          : item.rx_offered;
  assign wd = swap ? msp_pkg::byte_reverse(item.write_data) : item.write_data;

  always_comb begin
    w              = '{ready: rx_ready, held: rx_byte_held, used: 2'd0};
    rx_enable_next = rx_enable;
    tx_enable_next = tx_enable;
    rx_line_next   = rx_line;
    tx_line_next   = tx_line;
    rdata          = '0;
    ok             = 1'b1;
    txv            = 1'b0;
    txb            = '0;
    case (item.req_type)
      msp_pkg::REQ_READ: begin
        case (item.word_index)
          msp_pkg::WORD_RX_STATUS: begin
            w     = pull(w, offer_n, item.rx_first, item.rx_second);
            rdata = {30'd0, rx_enable, w.ready};
          end
          msp_pkg::WORD_RX_DATA: begin
            w = pull(w, offer_n, item.rx_first, item.rx_second);
            if (w.ready) begin
              rdata = {24'd0, w.held};
              if (!item.debug_access) begin
                w.ready = 1'b0;
              end
            end
            if (rx_enable) begin
              w = pull(w, offer_n, item.rx_first, item.rx_second);
            end
            rx_line_next = rx_enable & w.ready;
          end
          msp_pkg::WORD_TX_STATUS: begin
            rdata = {30'd0, tx_enable, msp_pkg::TX_READY};
          end
          default: begin
            ok = 1'b0;
          end
        endcase
        if (swap) begin
          rdata = msp_pkg::byte_reverse(rdata);
        end
      end
      msp_pkg::REQ_WRITE: begin
        case (item.word_index)
          msp_pkg::WORD_RX_STATUS: begin
            rx_enable_next = wd[msp_pkg::IE_BIT];
            if (rx_enable_next) begin
              w = pull(w, offer_n, item.rx_first, item.rx_second);
            end
            rx_line_next = rx_enable_next & w.ready;
          end
          msp_pkg::WORD_TX_STATUS: begin
            tx_enable_next = wd[msp_pkg::IE_BIT];
            tx_line_next   = tx_enable_next;
          end
          msp_pkg::WORD_TX_DATA: begin
            txv          = 1'b1;
            txb          = wd[7:0];
            tx_line_next = tx_enable;
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      msp_pkg::REQ_RX_CHECK: begin
        if (rx_enable) begin
          w = pull(w, offer_n, item.rx_first, item.rx_second);
        end
        rx_line_next = rx_enable & w.ready;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign take_count_next = take_count + {30'd0, w.used};

  always_comb begin
    result.read_data      = rdata;
    result.access_ok      = ok;
    result.rx_consumed    = w.used;
    result.tx_valid       = txv;
    result.tx_out         = txb;
    result.rx_irq         = rx_line_next;
    result.tx_irq         = tx_line_next;
    result.rx_irq_changed = rx_line_next ^ rx_line;
    result.tx_irq_changed = tx_line_next ^ tx_line;
    result.bytes_taken    = take_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_ready     <= 1'b0;
      rx_enable    <= 1'b0;
      rx_byte_held <= '0;
      tx_enable    <= 1'b0;
      rx_line      <= 1'b0;
      tx_line      <= 1'b0;
      take_count   <= '0;
    end else if (advance) begin
      rx_ready     <= w.ready;
      rx_enable    <= rx_enable_next;
      rx_byte_held <= w.held;
      tx_enable    <= tx_enable_next;
      rx_line      <= rx_line_next;
      tx_line      <= tx_line_next;
      take_count   <= take_count_next;
    end
  end

endmodule

// File: rtl/mmio_serial_port_registers_unit.sv
// top level of the memory-mapped serial port register block
//
//   channel | signals                          | direction
//   in      | in_valid / in_ready + item ports | beat into the block
//   out     | out_valid / out_ready + results  | beat out of the block
//   cfg     | psel penable pwrite paddr ...    | register writes and reads
//
// one beat per cycle sustained while the out channel is ready; a beat passes through the input
// register, then one combinational step into the result register
// the state registers update when a beat moves from the input to the result register
// a stalled out channel holds the result and stops that move; the input register still
// takes one more beat. rst is synchronous and clears state, flags and both valids
module mmio_serial_port_registers_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     req_type,
  input  logic [1:0]                     word_index,
  input  logic [31:0]                    write_data,
  input  logic                           debug_access,
  input  logic [1:0]                     rx_offered,
  input  logic [7:0]                     rx_first,
  input  logic [7:0]                     rx_second,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    read_data,
  output logic                           access_ok,
  output logic [1:0]                     rx_consumed,
  output logic                           tx_valid,
  output logic [7:0]                     tx_out,
  output logic                           rx_irq,
  output logic                           tx_irq,
  output logic                           rx_irq_changed,
  output logic                           tx_irq_changed,
  output logic [31:0]                    bytes_taken,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  msp_pkg::item_t   item;
  logic             item_valid;
  msp_pkg::result_t step;
  msp_pkg::result_t res;
  logic             advance;
  logic             swap;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= (in_valid && in_ready) || (item_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{req_type: req_type, word_index: word_index, write_data: write_data,
                debug_access: debug_access, rx_offered: rx_offered,
                rx_first: rx_first, rx_second: rx_second};
    end
  end

  msp_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .swap    (swap)
  );

  msp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .swap    (swap),
    .item    (item),
    .result  (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step;
    end
  end

  assign read_data      = res.read_data;
  assign access_ok      = res.access_ok;
  assign rx_consumed    = res.rx_consumed;
  assign tx_valid       = res.tx_valid;
  assign tx_out         = res.tx_out;
  assign rx_irq         = res.rx_irq;
  assign tx_irq         = res.tx_irq;
  assign rx_irq_changed = res.rx_irq_changed;
  assign tx_irq_changed = res.tx_irq_changed;
  assign bytes_taken    = res.bytes_taken;

endmodule

// File: rtl/msp_checker.sv
// port-level checks of the register block, bound to the top level
module msp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        access_ok,
  input logic [1:0]  rx_consumed,
  input logic        tx_valid,
  input logic [7:0]  tx_out
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(rx_consumed))
    else $error("result beat changed while stalled");

  a_no_take_on_bad_access: assert property (@(posedge clk) disable iff (rst)
    out_valid && !access_ok |-> rx_consumed == 2'd0 && !tx_valid)
    else $error("rejected access took rx bytes or sent a tx byte");

  a_tx_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_out == 8'd0)
    else $error("tx byte shown without a send");

  a_consumed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rx_consumed != 2'd3)
    else $error("more than two rx bytes taken");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind mmio_serial_port_registers_unit msp_checker u_msp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .read_data   (read_data),
  .access_ok   (access_ok),
  .rx_consumed (rx_consumed),
  .tx_valid    (tx_valid),
  .tx_out      (tx_out)
);

// File: dv/msp_result_checker.sv
// checker for the serial port register block: predicts each result beat and compares it
module msp_result_checker
  import msp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            req_type,
  input  logic [1:0]            word_index,
  input  logic [31:0]           write_data,
  input  logic                  debug_access,
  input  logic [1:0]            rx_offered,
  input  logic [7:0]            rx_first,
  input  logic [7:0]            rx_second,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [31:0]           read_data,
  input  logic                  access_ok,
  input  logic [1:0]            rx_consumed,
  input  logic                  tx_valid,
  input  logic [7:0]            tx_out,
  input  logic                  rx_irq,
  input  logic                  tx_irq,
  input  logic                  rx_irq_changed,
  input  logic                  tx_irq_changed,
  input  logic [31:0]           bytes_taken,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    beats_out
);

  localparam logic [CFG_ADDR_W-1:0] SWAP_ADDR = CFG_ADDR_W'({REG_SWAP, 2'b00});

  // mirror of the block's registers
  logic        swap_on;
  logic        rx_full;
  logic        rx_ie;
  logic [7:0]  rx_held;
  logic        tx_ie;
  logic        rx_level;
  logic        tx_level;
  logic [31:0] taken_total;

  // bytes the receive source offers during the current beat
  logic [1:0]  offer_cnt;
  logic [1:0]  offer_taken;
  logic [7:0]  offer_byte [2];

  result_t     pending_replies [$];
  int          errors;
  int          seen;

  function automatic void take_offered();
    if (!rx_full && offer_taken < offer_cnt) begin
      rx_held = offer_byte[offer_taken[0]];
      offer_taken++;
      rx_full = 1'b1;
      taken_total++;
    end
  endfunction

  function automatic void rx_poll();
    if (rx_ie)
      take_offered();
    rx_level = rx_ie & rx_full;
  endfunction

  function automatic result_t serial_port_step(item_t it);
    result_t     r;
    logic [31:0] wd;
    logic        rx_was;
    logic        tx_was;
    r = '0;
    r.access_ok = 1'b1;
    rx_was = rx_level;
    tx_was = tx_level;
    offer_cnt = (it.rx_offered > OFFER_MAX) ? OFFER_MAX : it.rx_offered;
    offer_taken = '0;
    offer_byte[0] = it.rx_first;
    offer_byte[1] = it.rx_second;
    wd = swap_on ? byte_reverse(it.write_data) : it.write_data;
    case (req_t'(it.req_type))
      REQ_READ: begin
        case (it.word_index)
          WORD_RX_STATUS: begin
            take_offered();
            r.read_data = {30'd0, rx_ie, rx_full};
          end
          WORD_RX_DATA: begin
            take_offered();
            if (rx_full) begin
              r.read_data = {24'd0, rx_held};
              if (!it.debug_access) begin
                rx_full = 1'b0;
                rx_level = rx_ie & rx_full;
              end
            end
            rx_poll();
          end
          WORD_TX_STATUS: r.read_data = {30'd0, tx_ie, TX_READY};
          default: r.access_ok = 1'b0;
        endcase
        if (swap_on)
          r.read_data = {<<8{r.read_data}};
      end
      REQ_WRITE: begin
        case (it.word_index)
          WORD_RX_STATUS: begin
            rx_ie = wd[IE_BIT];
            rx_poll();
          end
          WORD_TX_STATUS: begin
            tx_ie = wd[IE_BIT];
            tx_level = tx_ie;
          end
          WORD_TX_DATA: begin
            r.tx_valid = 1'b1;
            r.tx_out = wd[7:0];
            tx_level = tx_ie;
          end
          default: r.access_ok = 1'b0;
        endcase
      end
      REQ_RX_CHECK: rx_poll();
      default: r.access_ok = 1'b0;
    endcase
    r.rx_consumed = offer_taken;
    r.rx_irq = rx_level;
    r.tx_irq = tx_level;
    r.rx_irq_changed = rx_level != rx_was;
    r.tx_irq_changed = tx_level != tx_was;
    r.bytes_taken = taken_total;
    return r;
  endfunction

  task automatic compare_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (errors < 10)
        $display("mismatch in %s on beat %0d: expected %h, got %h", label, seen, want, got);
      errors++;
    end
  endtask

  initial begin
    fail_count = 0;
    beats_out = 0;
    errors = 0;
    seen = 0;
  end

  always @(posedge clk) begin : watch
    result_t want;
    item_t   beat;
    if (rst) begin
      swap_on = 1'b0;
      rx_full = 1'b0;
      rx_ie = 1'b0;
      rx_held = '0;
      tx_ie = 1'b0;
      rx_level = 1'b0;
      tx_level = 1'b0;
      taken_total = '0;
      pending_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          if (errors < 10)
            $display("result beat %0d arrived with nothing expected", seen);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          compare_field("read_data", want.read_data, read_data);
          compare_field("access_ok", 32'(want.access_ok), 32'(access_ok));
          compare_field("rx_consumed", 32'(want.rx_consumed), 32'(rx_consumed));
          compare_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
          compare_field("tx_out", 32'(want.tx_out), 32'(tx_out));
          compare_field("rx_irq", 32'(want.rx_irq), 32'(rx_irq));
          compare_field("tx_irq", 32'(want.tx_irq), 32'(tx_irq));
          compare_field("rx_irq_changed", 32'(want.rx_irq_changed), 32'(rx_irq_changed));
          compare_field("tx_irq_changed", 32'(want.tx_irq_changed), 32'(tx_irq_changed));
          compare_field("bytes_taken", want.bytes_taken, bytes_taken);
        end
        seen++;
      end
      if (in_valid && in_ready) begin
        beat.req_type = req_type;
        beat.word_index = word_index;
        beat.write_data = write_data;
        beat.debug_access = debug_access;
        beat.rx_offered = rx_offered;
        beat.rx_first = rx_first;
        beat.rx_second = rx_second;
        pending_replies.push_back(serial_port_step(beat));
      end
      if (psel && penable && pwrite && pready && paddr == SWAP_ADDR)
        swap_on = pwdata[0];
    end
    fail_count <= errors;
    beats_out <= seen;
  end

endmodule

// File: dv/testbench.sv
// top of the serial port register block testbench: clock, reset, stimulus and verdict
module testbench;
  import msp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] SWAP_ADDR = CFG_ADDR_W'({REG_SWAP, 2'b00});
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 356;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            req_type = '0;
  logic [1:0]            word_index = '0;
  logic [31:0]           write_data = '0;
  logic                  debug_access = 1'b0;
  logic [1:0]            rx_offered = '0;
  logic [7:0]            rx_first = '0;
  logic [7:0]            rx_second = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           read_data;
  logic                  access_ok;
  logic [1:0]            rx_consumed;
  logic                  tx_valid;
  logic [7:0]            tx_out;
  logic                  rx_irq;
  logic                  tx_irq;
  logic                  rx_irq_changed;
  logic                  tx_irq_changed;
  logic [31:0]           bytes_taken;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  int                    fail_count;
  int                    beats_out;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_sent = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  mmio_serial_port_registers_unit uut (.*);
  msp_result_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic item_t make_request(logic [1:0] req, logic [1:0] word, logic [31:0] wd,
                                         logic dbg, logic [1:0] offered, logic [7:0] b0,
                                         logic [7:0] b1);
    item_t it;
    it.req_type = req;
    it.word_index = word;
    it.write_data = wd;
    it.debug_access = dbg;
    it.rx_offered = offered;
    it.rx_first = b0;
    it.rx_second = b1;
    return it;
  endfunction

  function automatic item_t random_request();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 40)
      it.req_type = REQ_READ;
    else if (pick < 75)
      it.req_type = REQ_WRITE;
    else if (pick < 95)
      it.req_type = REQ_RX_CHECK;
    else
      it.req_type = REQ_NONE;
    it.word_index = 2'($urandom_range(3));
    it.write_data = $urandom();
    it.debug_access = ($urandom_range(3) == 0);
    it.rx_offered = 2'($urandom_range(3));
    it.rx_first = 8'($urandom_range(255));
    it.rx_second = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic send_beat(item_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct)
        @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req_type;
    word_index <= it.word_index;
    write_data <= it.write_data;
    debug_access <= it.debug_access;
    rx_offered <= it.rx_offered;
    rx_first <= it.rx_first;
    rx_second <= it.rx_second;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (beats_out != beats_sent)
      @(posedge clk);
  endtask

  task automatic write_swap(logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SWAP_ADDR;
    pwdata <= ($urandom() & ~32'd1) | {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: no swap
    send_beat(make_request(REQ_READ, WORD_RX_STATUS, 32'd0, 1'b0, 2'd0, 8'h00, 8'h00));
    send_beat(make_request(REQ_READ, WORD_RX_STATUS, 32'd0, 1'b1, 2'd2, 8'hff, 8'h00));
    send_beat(make_request(REQ_READ, WORD_RX_DATA, 32'd0, 1'b1, 2'd2, 8'h11, 8'h22));
    send_beat(make_request(REQ_READ, WORD_RX_DATA, 32'd0, 1'b0, 2'd0, 8'h00, 8'hff));
    send_beat(make_request(REQ_RX_CHECK, WORD_TX_DATA, '1, 1'b0, 2'd2, 8'h33, 8'h44));
    send_beat(make_request(REQ_WRITE, WORD_RX_STATUS, 32'h2, 1'b0, 2'd3, 8'h55, 8'h66));
    send_beat(make_request(REQ_READ, WORD_RX_DATA, 32'd0, 1'b0, 2'd1, 8'h77, 8'h88));
    send_beat(make_request(REQ_READ, WORD_RX_DATA, 32'd0, 1'b0, 2'd0, 8'h99, 8'haa));
    send_beat(make_request(REQ_READ, WORD_RX_DATA, 32'd0, 1'b0, 2'd2, 8'h01, 8'h80));
    send_beat(make_request(REQ_RX_CHECK, WORD_RX_STATUS, 32'd0, 1'b0, 2'd2, 8'hbb, 8'hcc));
    send_beat(make_request(REQ_WRITE, WORD_RX_STATUS, 32'hffff_fffd, 1'b0, 2'd0, 8'h00,
                           8'h00));
    send_beat(make_request(REQ_WRITE, WORD_TX_STATUS, '1, 1'b0, 2'd0, 8'h00, 8'h00));
    send_beat(make_request(REQ_READ, WORD_TX_STATUS, 32'd0, 1'b0, 2'd0, 8'h00, 8'h00));
    send_beat(make_request(REQ_WRITE, WORD_TX_DATA, '1, 1'b0, 2'd0, 8'h00, 8'h00));
    send_beat(make_request(REQ_WRITE, WORD_TX_DATA, 32'd0, 1'b1, 2'd0, 8'h00, 8'h00));
    send_beat(make_request(REQ_READ, WORD_TX_DATA, 32'd0, 1'b0, 2'd2, 8'hdd, 8'hee));
    send_beat(make_request(REQ_WRITE, WORD_RX_DATA, 32'h2, 1'b0, 2'd2, 8'hdd, 8'hee));
    send_beat(make_request(REQ_NONE, WORD_RX_STATUS, 32'h2, 1'b1, 2'd2, 8'hdd, 8'hee));
    send_beat(make_request(REQ_WRITE, WORD_TX_STATUS, 32'd0, 1'b0, 2'd0, 8'h00, 8'h00));
    send_beat(make_request(REQ_READ, WORD_RX_DATA, 32'd0, 1'b1, 2'd0, 8'h00, 8'h00));
    drain();

    // directed: swapped byte order
    write_swap(1'b1);
    send_beat(make_request(REQ_WRITE, WORD_RX_STATUS, 32'h0200_0000, 1'b0, 2'd2, 8'h5a,
                           8'ha5));
    send_beat(make_request(REQ_READ, WORD_RX_STATUS, 32'd0, 1'b0, 2'd0, 8'h00, 8'h00));
    send_beat(make_request(REQ_WRITE, WORD_TX_DATA, 32'hab00_0000, 1'b0, 2'd0, 8'h00, 8'h00));
    send_beat(make_request(REQ_READ, WORD_RX_DATA, 32'd0, 1'b0, 2'd2, 8'hc3, 8'h3c));
    send_beat(make_request(REQ_WRITE, WORD_RX_STATUS, 32'h0000_0002, 1'b0, 2'd2, 8'h0f,
                           8'hf0));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_swap(phase[0]);
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 0 && n == 100)
          hold_asks <= hold_asks + 1;
        send_beat(random_request());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
